// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the execute unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("next-cycle check failed");

`endif

// ===== design/rvex_pkg.sv =====
// ----------------------------------------------------------------------------
// RV32I execute unit package
// Widths, memory geometry and operation codes shared by the execute unit.
// ----------------------------------------------------------------------------
package rvex_pkg;

	localparam int XLEN           = 32;
	localparam int REG_COUNT      = 32;
	localparam int REG_IDX_W      = 5;
	localparam int DATA_MEM_BYTES = 4096;
	localparam int DMEM_LANES     = 4;
	localparam int DMEM_ROWS      = DATA_MEM_BYTES / DMEM_LANES;
	localparam int DMEM_ROW_W     = $clog2(DMEM_ROWS);
	localparam int S_TDATA_W      = 56;
	localparam int M_TDATA_W      = 112;

	localparam logic [XLEN-1:0] PC_STEP = 32'd4;

	typedef enum logic [5:0] {
		ACT_LUI   = 6'd0,
		ACT_AUIPC = 6'd1,
		ACT_JAL   = 6'd2,
		ACT_JALR  = 6'd3,
		ACT_BEQ   = 6'd4,
		ACT_BNE   = 6'd5,
		ACT_BLT   = 6'd6,
		ACT_BGE   = 6'd7,
		ACT_BLTU  = 6'd8,
		ACT_BGEU  = 6'd9,
		ACT_LB    = 6'd10,
		ACT_LH    = 6'd11,
		ACT_LW    = 6'd12,
		ACT_LBU   = 6'd13,
		ACT_LHU   = 6'd14,
		ACT_SB    = 6'd15,
		ACT_SH    = 6'd16,
		ACT_SW    = 6'd17,
		ACT_ADDI  = 6'd18,
		ACT_SLTI  = 6'd19,
		ACT_SLTIU = 6'd20,
		ACT_XORI  = 6'd21,
		ACT_ORI   = 6'd22,
		ACT_ANDI  = 6'd23,
		ACT_SLLI  = 6'd24,
		ACT_SRLI  = 6'd25,
		ACT_SRAI  = 6'd26,
		ACT_ADD   = 6'd27,
		ACT_SUB   = 6'd28,
		ACT_SLT   = 6'd29,
		ACT_SLTU  = 6'd30,
		ACT_XOR   = 6'd31,
		ACT_OR    = 6'd32,
		ACT_AND   = 6'd33,
		ACT_SLL   = 6'd34,
		ACT_SRL   = 6'd35,
		ACT_SRA   = 6'd36
	} action_t;

	typedef enum logic [1:0] {
		MEM_NONE  = 2'd0,
		MEM_LOAD  = 2'd1,
		MEM_STORE = 2'd2
	} mem_kind_t;

endpackage

// ===== design/rv32i_execute_unit.sv =====
// ----------------------------------------------------------------------------
// RV32I execute unit
// Executes one decoded RV32I instruction per beat against its own register
// file, program counter and byte-addressed data memory.
// ----------------------------------------------------------------------------
// The unit takes one decoded instruction per input beat and returns one result
// beat per instruction, in order, at a sustained rate of one instruction per
// clock while m_tready is high. In the execute stage (s1) the register
// operands, ALU result, branch decision, next PC and memory address are formed
// and stores are written; the instruction then sits in the result register
// (s2), where load data arrives from the data memory and the destination
// register is written when the result beat is taken. Its result is forwarded
// back to s1, so dependent instructions, loads included, issue back to back.
// The register file lives in two RAM copies (one per read port); the data
// memory is four byte lanes of DATA_MEM_BYTES/4 rows each, so a misaligned
// access that wraps across the end of memory still touches every lane once.
// After reset the unit sweeps the data memory clear, one row per cycle, across
// DMEM_ROWS rows (1024 at the default size); s_tready stays low until then,
// while reset_pc writes are accepted throughout. The program counter comes out
// of reset as the reset value of reset_pc.
// ----------------------------------------------------------------------------
module rv32i_execute_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration: reset_pc register.
	input  logic                            reset_pc_we,
	input  logic [rvex_pkg::XLEN-1:0]       reset_pc_wdata,
	// Instruction stream.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// action[5:0], dest_reg[10:6], src1_reg[15:11], src2_reg[20:16],
	// immediate[52:21], zero pad[55:53].
	input  logic [rvex_pkg::S_TDATA_W-1:0]  s_tdata,
	// Result stream.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// next_pc[31:0], reg_written[32], written_index[37:33],
	// written_value[69:38], branch_taken[70], mem_kind[72:71],
	// mem_address[104:73], zero pad[111:105].
	output logic [rvex_pkg::M_TDATA_W-1:0]  m_tdata
);

	import rvex_pkg::*;

	// Input beat fields.
	action_t              in_action;
	logic [REG_IDX_W-1:0] in_rd;
	logic [REG_IDX_W-1:0] in_rs1;
	logic [REG_IDX_W-1:0] in_rs2;
	logic [XLEN-1:0]      in_imm;

	assign in_action = action_t'(s_tdata[5:0]);
	assign in_rd     = s_tdata[10:6];
	assign in_rs1    = s_tdata[15:11];
	assign in_rs2    = s_tdata[20:16];
	assign in_imm    = s_tdata[52:21];

	// Architectural and housekeeping state.
	logic [XLEN-1:0]       reset_pc_q;
	logic [XLEN-1:0]       pc_q;
	logic                  pc_load_q;
	logic                  clear_done_q;
	logic [DMEM_ROW_W-1:0] clr_row_q;
	logic [REG_COUNT-1:0]  rf_valid_q;

	// Execute stage.
	logic                 valid_s1;
	action_t              action_s1;
	logic [REG_IDX_W-1:0] rd_s1;
	logic [REG_IDX_W-1:0] rs1_s1;
	logic [REG_IDX_W-1:0] rs2_s1;
	logic [XLEN-1:0]      imm_s1;
	logic                 byp1_hit_s1;
	logic [XLEN-1:0]      byp1_val_s1;
	logic                 byp2_hit_s1;
	logic [XLEN-1:0]      byp2_val_s1;

	// Result stage.
	logic                 valid_s2;
	logic [XLEN-1:0]      next_pc_s2;
	logic                 reg_written_s2;
	logic [REG_IDX_W-1:0] widx_s2;
	logic [XLEN-1:0]      wval_s2;
	logic                 taken_s2;
	mem_kind_t            mem_kind_s2;
	logic [XLEN-1:0]      addr_s2;
	action_t              action_s2;
	logic [1:0]           addr_lo_s2;

	// Handshake and pipeline control.
	logic accept;
	logic s2_free;
	logic s1_adv;
	logic rf_we;

	assign accept   = s_tvalid && s_tready;
	assign s2_free  = !valid_s2 || m_tready;
	assign s1_adv   = valid_s1 && s2_free;
	assign s_tready = clear_done_q && (!valid_s1 || s2_free);
	assign rf_we    = valid_s2 && m_tready && reg_written_s2;
	assign m_tvalid = valid_s2;

	// ------------------------------------------------------------------
	// Result stage: load data alignment and extension.
	// ------------------------------------------------------------------
	logic [7:0]      dm_rdata [DMEM_LANES];
	logic [XLEN-1:0] ld_word;
	logic [XLEN-1:0] ld_val;
	logic [XLEN-1:0] s2_result;
	logic [XLEN-1:0] out_wval;

	// Byte k of the access sits in lane (address + k) mod 4.
	always_comb begin
		for (int k = 0; k < DMEM_LANES; k++) begin
			ld_word[8*k +: 8] = dm_rdata[2'(addr_lo_s2 + 2'(k))];
		end
	end

	always_comb begin
		case (action_s2)
			ACT_LB:  ld_val = {{24{ld_word[7]}}, ld_word[7:0]};
			ACT_LH:  ld_val = {{16{ld_word[15]}}, ld_word[15:0]};
			ACT_LBU: ld_val = {24'd0, ld_word[7:0]};
			ACT_LHU: ld_val = {16'd0, ld_word[15:0]};
			default: ld_val = ld_word;
		endcase
	end

	assign s2_result = (mem_kind_s2 == MEM_LOAD) ? ld_val : wval_s2;
	assign out_wval  = reg_written_s2 ? s2_result : '0;

	assign m_tdata = {7'd0, addr_s2, mem_kind_s2, taken_s2, out_wval, widx_s2,
		reg_written_s2, next_pc_s2};

	// ------------------------------------------------------------------
	// Register file: two read copies, written from the result stage.
	// ------------------------------------------------------------------
	logic [XLEN-1:0] rf1_rdata;
	logic [XLEN-1:0] rf2_rdata;

	rvex_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_rs1 (
		.clk   (clk),
		.we    (rf_we),
		.waddr (widx_s2),
		.wdata (s2_result),
		.re    (accept),
		.raddr (in_rs1),
		.rdata (rf1_rdata)
	);

	rvex_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_rs2 (
		.clk   (clk),
		.we    (rf_we),
		.waddr (widx_s2),
		.wdata (s2_result),
		.re    (accept),
		.raddr (in_rs2),
		.rdata (rf2_rdata)
	);

	// Operand selection. The instruction in s2 is the only older one whose
	// register write is still pending; a write landing on the read edge, or a
	// never-written entry (x0 among them), was captured in the bypass register.
	logic [XLEN-1:0] op_a;
	logic [XLEN-1:0] op_b;

	always_comb begin
		if (valid_s2 && reg_written_s2 && widx_s2 == rs1_s1) begin
			op_a = s2_result;
		end else if (byp1_hit_s1) begin
			op_a = byp1_val_s1;
		end else begin
			op_a = rf1_rdata;
		end
		if (valid_s2 && reg_written_s2 && widx_s2 == rs2_s1) begin
			op_b = s2_result;
		end else if (byp2_hit_s1) begin
			op_b = byp2_val_s1;
		end else begin
			op_b = rf2_rdata;
		end
	end

	// ------------------------------------------------------------------
	// Execute stage.
	// ------------------------------------------------------------------
	logic [XLEN-1:0] sum_ai;
	logic [XLEN-1:0] pc_imm;
	logic [XLEN-1:0] pc_plus4;
	logic [4:0]      reg_sh;
	logic            lt_ab;
	logic            ltu_ab;
	logic [XLEN-1:0] ex_val;
	logic            ex_wr;
	logic            ex_cond;
	logic            ex_taken;
	mem_kind_t       ex_kind;
	logic [XLEN-1:0] ex_addr;
	logic [XLEN-1:0] ex_npc;
	logic            ex_reg_written;
	logic [2:0]      st_bytes;

	assign sum_ai   = op_a + imm_s1;
	assign pc_imm   = pc_q + imm_s1;
	assign pc_plus4 = pc_q + PC_STEP;
	assign reg_sh   = op_b[4:0];
	assign lt_ab    = $signed(op_a) < $signed(op_b);
	assign ltu_ab   = op_a < op_b;

	always_comb begin
		ex_val   = '0;
		ex_wr    = 1'b0;
		ex_cond  = 1'b0;
		ex_taken = 1'b0;
		ex_kind  = MEM_NONE;
		ex_addr  = '0;
		ex_npc   = pc_plus4;
		case (action_s1)
			ACT_LUI: begin
				ex_val = imm_s1;
				ex_wr  = 1'b1;
			end
			ACT_AUIPC: begin
				ex_val = pc_imm;
				ex_wr  = 1'b1;
			end
			ACT_JAL: begin
				ex_val   = pc_plus4;
				ex_wr    = 1'b1;
				ex_taken = 1'b1;
				ex_npc   = pc_imm;
			end
			ACT_JALR: begin
				ex_val   = pc_plus4;
				ex_wr    = 1'b1;
				ex_taken = 1'b1;
				ex_npc   = {sum_ai[XLEN-1:1], 1'b0};
			end
			ACT_BEQ:  ex_cond = (op_a == op_b);
			ACT_BNE:  ex_cond = (op_a != op_b);
			ACT_BLT:  ex_cond = lt_ab;
			ACT_BGE:  ex_cond = !lt_ab;
			ACT_BLTU: ex_cond = ltu_ab;
			ACT_BGEU: ex_cond = !ltu_ab;
			ACT_LB, ACT_LH, ACT_LW, ACT_LBU, ACT_LHU: begin
				ex_kind = MEM_LOAD;
				ex_addr = sum_ai;
				ex_wr   = 1'b1;
			end
			ACT_SB, ACT_SH, ACT_SW: begin
				ex_kind = MEM_STORE;
				ex_addr = sum_ai;
			end
			ACT_ADDI: begin
				ex_val = sum_ai;
				ex_wr  = 1'b1;
			end
			ACT_SLTI: begin
				ex_val = {31'd0, $signed(op_a) < $signed(imm_s1)};
				ex_wr  = 1'b1;
			end
			ACT_SLTIU: begin
				ex_val = {31'd0, op_a < imm_s1};
				ex_wr  = 1'b1;
			end
			ACT_XORI: begin
				ex_val = op_a ^ imm_s1;
				ex_wr  = 1'b1;
			end
			ACT_ORI: begin
				ex_val = op_a | imm_s1;
				ex_wr  = 1'b1;
			end
			ACT_ANDI: begin
				ex_val = op_a & imm_s1;
				ex_wr  = 1'b1;
			end
			ACT_SLLI: begin
				ex_val = op_a << rs2_s1;
				ex_wr  = 1'b1;
			end
			ACT_SRLI: begin
				ex_val = op_a >> rs2_s1;
				ex_wr  = 1'b1;
			end
			ACT_SRAI: begin
				ex_val = XLEN'($signed(op_a) >>> rs2_s1);
				ex_wr  = 1'b1;
			end
			ACT_ADD: begin
				ex_val = op_a + op_b;
				ex_wr  = 1'b1;
			end
			ACT_SUB: begin
				ex_val = op_a - op_b;
				ex_wr  = 1'b1;
			end
			ACT_SLT: begin
				ex_val = {31'd0, lt_ab};
				ex_wr  = 1'b1;
			end
			ACT_SLTU: begin
				ex_val = {31'd0, ltu_ab};
				ex_wr  = 1'b1;
			end
			ACT_XOR: begin
				ex_val = op_a ^ op_b;
				ex_wr  = 1'b1;
			end
			ACT_OR: begin
				ex_val = op_a | op_b;
				ex_wr  = 1'b1;
			end
			ACT_AND: begin
				ex_val = op_a & op_b;
				ex_wr  = 1'b1;
			end
			ACT_SLL: begin
				ex_val = op_a << reg_sh;
				ex_wr  = 1'b1;
			end
			ACT_SRL: begin
				ex_val = op_a >> reg_sh;
				ex_wr  = 1'b1;
			end
			ACT_SRA: begin
				ex_val = XLEN'($signed(op_a) >>> reg_sh);
				ex_wr  = 1'b1;
			end
			default: begin
				// Unknown operations fall through as a plain PC step.
			end
		endcase
		if (ex_cond) begin
			ex_taken = 1'b1;
			ex_npc   = pc_imm;
		end
	end

	assign ex_reg_written = ex_wr && (rd_s1 != '0);

	always_comb begin
		case (action_s1)
			ACT_SB:  st_bytes = 3'd1;
			ACT_SH:  st_bytes = 3'd2;
			default: st_bytes = 3'd4;
		endcase
	end

	// ------------------------------------------------------------------
	// Data memory: four byte lanes. Lane b serves the access byte at offset
	// (b - address) mod 4; lanes below the start lane take the next row.
	// ------------------------------------------------------------------
	for (genvar b = 0; b < DMEM_LANES; b++) begin : g_lane
		logic [1:0]            lane_off;
		logic [DMEM_ROW_W-1:0] lane_row;
		logic                  lane_st;
		logic [7:0]            lane_wdata;
		logic                  dm_we;
		logic [DMEM_ROW_W-1:0] dm_waddr;
		logic [7:0]            dm_wdata;
		logic                  dm_re;

		assign lane_off   = 2'(b) - sum_ai[1:0];
		assign lane_row   = sum_ai[DMEM_ROW_W+1:2] +
			DMEM_ROW_W'(2'(b) < sum_ai[1:0]);
		assign lane_st    = s1_adv && (ex_kind == MEM_STORE) &&
			({1'b0, lane_off} < st_bytes);
		assign lane_wdata = 8'(op_b >> {lane_off, 3'b000});

		assign dm_we    = !clear_done_q || lane_st;
		assign dm_waddr = clear_done_q ? lane_row : clr_row_q;
		assign dm_wdata = clear_done_q ? lane_wdata : '0;
		assign dm_re    = s1_adv && (ex_kind == MEM_LOAD);

		rvex_ram #(.WIDTH(8), .DEPTH(DMEM_ROWS)) u_dmem (
			.clk   (clk),
			.we    (dm_we),
			.waddr (dm_waddr),
			.wdata (dm_wdata),
			.re    (dm_re),
			.raddr (lane_row),
			.rdata (dm_rdata[b])
		);
	end

	// ------------------------------------------------------------------
	// Control registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_pc_q   <= '0;
			pc_q         <= '0;
			pc_load_q    <= 1'b1;
			clear_done_q <= 1'b0;
			clr_row_q    <= '0;
			rf_valid_q   <= '0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
		end else begin
			if (reset_pc_we) begin
				reset_pc_q <= reset_pc_wdata;
			end
			// The PC picks up the reset vector once, right after reset.
			if (pc_load_q) begin
				pc_q      <= reset_pc_q;
				pc_load_q <= 1'b0;
			end else if (s1_adv) begin
				pc_q <= ex_npc;
			end
			if (!clear_done_q) begin
				clr_row_q <= clr_row_q + 1'b1;
				if (clr_row_q == '1) begin
					clear_done_q <= 1'b1;
				end
			end
			if (rf_we) begin
				rf_valid_q[widx_s2] <= 1'b1;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Payload registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1   <= in_action;
			rd_s1       <= in_rd;
			rs1_s1      <= in_rs1;
			rs2_s1      <= in_rs2;
			imm_s1      <= in_imm;
			byp1_hit_s1 <= (rf_we && widx_s2 == in_rs1) || !rf_valid_q[in_rs1];
			byp1_val_s1 <= (rf_we && widx_s2 == in_rs1) ? s2_result : '0;
			byp2_hit_s1 <= (rf_we && widx_s2 == in_rs2) || !rf_valid_q[in_rs2];
			byp2_val_s1 <= (rf_we && widx_s2 == in_rs2) ? s2_result : '0;
		end
		if (s1_adv) begin
			next_pc_s2     <= ex_npc;
			reg_written_s2 <= ex_reg_written;
			widx_s2        <= ex_reg_written ? rd_s1 : '0;
			wval_s2        <= ex_reg_written ? ex_val : '0;
			taken_s2       <= ex_taken;
			mem_kind_s2    <= ex_kind;
			addr_s2        <= ex_addr;
			action_s2      <= action_s1;
			addr_lo_s2     <= sum_ai[1:0];
		end
	end

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
`include "assert_macros.svh"

	`ASSERT_IMPLIES(a_no_accept_while_clearing, clk, arst_n, accept, clear_done_q)
	`ASSERT_IMPLIES(a_store_writes_no_reg, clk, arst_n,
		valid_s2 && (mem_kind_s2 == MEM_STORE), !reg_written_s2)
	`ASSERT_IMPLIES(a_written_index_nonzero, clk, arst_n,
		valid_s2 && reg_written_s2, widx_s2 != '0)
	`ASSERT_NEXT(a_pc_tracks_result, clk, arst_n, s1_adv, pc_q == next_pc_s2)

endmodule

// ===== design/rvex_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module rvex_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// RV32I execute unit testbench
// Streams decoded RV32I instructions into the execute unit and checks every
// result beat against an in-bench model of the register file, program counter
// and byte data memory. Both stream sides idle and stall at random. One phase
// holds the result side off long enough to back up the instruction side.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rvex_pkg::*;

	// Largest 6-bit action code; everything above ACT_SRA is an unused code.
	localparam int ACT_CODE_MAX = 63;
	// Long result-side hold-off used once to fill the pipeline and stall the input.
	localparam int HOLD_CYCLES = 300;
	// Idle limit. It has to cover the data memory clearing sweep after reset
	// (one row per cycle) and the long hold-off, with a wide margin.
	localparam int QUIET_LIMIT = 4 * DMEM_ROWS + 4 * HOLD_CYCLES;
	// Byte index width of the model data memory.
	localparam int BYTE_ADDR_W = $clog2(DATA_MEM_BYTES);

	typedef struct packed {
		logic [5:0]  act;
		logic [4:0]  rd;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [31:0] imm;
	} instr_t;

	typedef struct {
		logic [31:0] next_pc;
		logic        reg_written;
		logic [4:0]  written_index;
		logic [31:0] written_value;
		logic        branch_taken;
		mem_kind_t   mem_kind;
		logic [31:0] mem_address;
	} result_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  reset_pc_we = 1'b0;
	logic [XLEN-1:0]       reset_pc_wdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// action[5:0], dest_reg[10:6], src1_reg[15:11], src2_reg[20:16],
	// immediate[52:21], zero pad[55:53].
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// next_pc[31:0], reg_written[32], written_index[37:33],
	// written_value[69:38], branch_taken[70], mem_kind[72:71],
	// mem_address[104:73], zero pad[111:105].
	logic [M_TDATA_W-1:0]  m_tdata;

	// Architectural state of the model, kept in step with accepted instructions.
	logic [31:0] arch_regs [REG_COUNT];
	logic [31:0] arch_pc;
	logic [7:0]  data_bytes [DATA_MEM_BYTES];
	logic [31:0] cfg_reset_pc;

	instr_t  instr_queue[$];
	result_t predicted_results[$];
	instr_t  cur_instr;

	int src_gap;
	int sink_stall;
	bit src_idle_en = 1'b1;
	bit sink_idle_en = 1'b1;
	int sent_count;
	int taken_results;
	bit long_hold_req;
	int mismatches;
	int quiet_cycles;

	rv32i_execute_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.reset_pc_we    (reset_pc_we),
		.reset_pc_wdata (reset_pc_wdata),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Executes one instruction on the model state and returns the result beat
	// the unit must produce for it. Memory bytes wrap modulo the memory size,
	// while the reported address is the full 32-bit sum.
	function automatic result_t execute_instr(instr_t ins);
		result_t                result;
		logic [31:0]            a, b, val, pc_next;
		logic [BYTE_ADDR_W-1:0] idx;
		logic                   wr, cond;
		int                     nbytes;
		a = (ins.rs1 == '0) ? '0 : arch_regs[ins.rs1];
		b = (ins.rs2 == '0) ? '0 : arch_regs[ins.rs2];
		pc_next = arch_pc + PC_STEP;
		val = '0;
		wr = 1'b0;
		cond = 1'b0;
		nbytes = 0;
		result.branch_taken = 1'b0;
		result.mem_kind = MEM_NONE;
		result.mem_address = '0;
		case (ins.act)
			ACT_LUI: begin val = ins.imm; wr = 1'b1; end
			ACT_AUIPC: begin val = arch_pc + ins.imm; wr = 1'b1; end
			ACT_JAL: begin
				val = arch_pc + PC_STEP;
				wr = 1'b1;
				result.branch_taken = 1'b1;
				pc_next = arch_pc + ins.imm;
			end
			ACT_JALR: begin
				val = arch_pc + PC_STEP;
				wr = 1'b1;
				result.branch_taken = 1'b1;
				pc_next = (a + ins.imm) & ~32'd1;
			end
			ACT_BEQ:  cond = (a == b);
			ACT_BNE:  cond = (a != b);
			ACT_BLT:  cond = ($signed(a) < $signed(b));
			ACT_BGE:  cond = !($signed(a) < $signed(b));
			ACT_BLTU: cond = (a < b);
			ACT_BGEU: cond = (a >= b);
			ACT_LB, ACT_LH, ACT_LW, ACT_LBU, ACT_LHU: begin
				result.mem_kind = MEM_LOAD;
				result.mem_address = a + ins.imm;
				wr = 1'b1;
				case (ins.act)
					ACT_LB, ACT_LBU: nbytes = 1;
					ACT_LW:          nbytes = 4;
					default:         nbytes = 2;
				endcase
				for (int k = 0; k < nbytes; k++) begin
					idx = BYTE_ADDR_W'((result.mem_address + 32'(k)) %
						32'(DATA_MEM_BYTES));
					val |= 32'(data_bytes[idx]) << (8 * k);
				end
				if (ins.act == ACT_LB)
					val = {{24{val[7]}}, val[7:0]};
				if (ins.act == ACT_LH)
					val = {{16{val[15]}}, val[15:0]};
			end
			ACT_SB, ACT_SH, ACT_SW: begin
				result.mem_kind = MEM_STORE;
				result.mem_address = a + ins.imm;
				nbytes = (ins.act == ACT_SB) ? 1 : ((ins.act == ACT_SH) ? 2 : 4);
				for (int k = 0; k < nbytes; k++) begin
					idx = BYTE_ADDR_W'((result.mem_address + 32'(k)) %
						32'(DATA_MEM_BYTES));
					data_bytes[idx] = b[8 * k +: 8];
				end
			end
			ACT_ADDI:  begin val = a + ins.imm; wr = 1'b1; end
			ACT_SLTI:  begin val = {31'b0, $signed(a) < $signed(ins.imm)}; wr = 1'b1; end
			ACT_SLTIU: begin val = {31'b0, a < ins.imm}; wr = 1'b1; end
			ACT_XORI:  begin val = a ^ ins.imm; wr = 1'b1; end
			ACT_ORI:   begin val = a | ins.imm; wr = 1'b1; end
			ACT_ANDI:  begin val = a & ins.imm; wr = 1'b1; end
			// Immediate shifts take the amount from the rs2 field itself.
			ACT_SLLI:  begin val = a << ins.rs2; wr = 1'b1; end
			ACT_SRLI:  begin val = a >> ins.rs2; wr = 1'b1; end
			ACT_SRAI:  begin val = $signed(a) >>> ins.rs2; wr = 1'b1; end
			ACT_ADD:   begin val = a + b; wr = 1'b1; end
			ACT_SUB:   begin val = a - b; wr = 1'b1; end
			ACT_SLT:   begin val = {31'b0, $signed(a) < $signed(b)}; wr = 1'b1; end
			ACT_SLTU:  begin val = {31'b0, a < b}; wr = 1'b1; end
			ACT_XOR:   begin val = a ^ b; wr = 1'b1; end
			ACT_OR:    begin val = a | b; wr = 1'b1; end
			ACT_AND:   begin val = a & b; wr = 1'b1; end
			// Register shifts use only the low five bits of rs2.
			ACT_SLL:   begin val = a << b[4:0]; wr = 1'b1; end
			ACT_SRL:   begin val = a >> b[4:0]; wr = 1'b1; end
			ACT_SRA:   begin val = $signed(a) >>> b[4:0]; wr = 1'b1; end
			default: ;
		endcase
		// Only the branch cases set cond; a taken branch is relative to this PC.
		if (cond) begin
			result.branch_taken = 1'b1;
			pc_next = arch_pc + ins.imm;
		end
		if (ins.rd == '0)
			wr = 1'b0;
		if (wr)
			arch_regs[ins.rd] = val;
		else
			val = '0;
		arch_pc = pc_next;
		result.next_pc = pc_next;
		result.reg_written = wr;
		result.written_index = wr ? ins.rd : '0;
		result.written_value = val;
		return result;
	endfunction

	// Immediates that sit on the edges of signed and unsigned ranges.
	function automatic logic [31:0] pick_special(int sel);
		case (sel % 7)
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return 32'h0000_0001;
			5: return 32'hFFFF_F800;
			default: return $urandom;
		endcase
	endfunction

	// Address offsets: mostly a small window so loads find earlier stores,
	// some around the end of memory so accesses wrap, some anywhere at all.
	function automatic logic [31:0] pick_offset();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return $urandom_range(0, 63);
		else if (sel < 8)
			return $urandom_range(DATA_MEM_BYTES - 8, DATA_MEM_BYTES + 4);
		else if (sel < 9)
			return -$urandom_range(1, 8);
		else
			return $urandom;
	endfunction

	task automatic push_instr(logic [5:0] act, logic [4:0] rd, logic [4:0] rs1,
			logic [4:0] rs2, logic [31:0] imm);
		instr_t ins;
		ins.act = act;
		ins.rd = rd;
		ins.rs1 = rs1;
		ins.rs2 = rs2;
		ins.imm = imm;
		instr_queue.push_back(ins);
	endtask

	// Directed opening: load a few edge values into registers, store a word
	// that straddles the end of memory, then run every action code once,
	// including an unused one, with loads reading across the wrap point.
	task automatic queue_directed();
		logic [4:0]  rd, rs1, rs2;
		logic [31:0] imm;
		logic [5:0]  op;
		@(negedge clk);
		push_instr(ACT_ADDI, 5'd1, 5'd0, 5'd0, 32'hFFFF_FFFF);
		push_instr(ACT_LUI, 5'd2, 5'd0, 5'd0, 32'h8000_0000);
		push_instr(ACT_ADDI, 5'd3, 5'd2, 5'd0, 32'hFFFF_FFFF);
		push_instr(ACT_SW, 5'd0, 5'd0, 5'd1, 32'(DATA_MEM_BYTES - 2));
		for (int k = 0; k <= int'(ACT_SRA) + 1; k++) begin
			op = (k > int'(ACT_SRA)) ? 6'(ACT_CODE_MAX) : 6'(k);
			// Destinations sweep down from x31, with x0 now and then.
			rd = (k % 6 == 5) ? 5'd0 : 5'(31 - k % 28);
			rs1 = 5'(1 + k % 3);
			rs2 = (k % 4 == 3) ? 5'd0 : 5'(1 + (k + 1) % 3);
			imm = pick_special(k);
			if (op >= ACT_BEQ && op <= ACT_BGEU) begin
				// 0x80000000 against 0x7FFFFFFF: signed and unsigned order differ.
				rs1 = 5'd2;
				rs2 = 5'd3;
			end else if (op >= ACT_LB && op <= ACT_SW) begin
				rs1 = 5'd0;
				imm = 32'hFFFF_FFFF;
			end else if (op >= ACT_SLLI && op <= ACT_SRAI) begin
				rs1 = 5'd2;
				rs2 = 5'd31;
			end
			push_instr(op, rd, rs1, rs2, imm);
		end
	endtask

	// Random instruction mix. Store/load pairs to nearby addresses make the data
	// memory matter; branches and jumps move the PC; LUI/ADDI/AUIPC seed
	// registers with edge values; unused codes are sprinkled in as noise.
	task automatic queue_random(int count);
		int          n, pick;
		logic [4:0]  base, rs1, rs2;
		logic [31:0] offs, imm, r13;
		@(negedge clk);
		n = 0;
		while (n < count) begin
			pick = $urandom_range(0, 19);
			rs1 = 5'($urandom);
			rs2 = ($urandom_range(0, 3) == 0) ? rs1 : 5'($urandom);
			if (pick < 5) begin
				base = ($urandom_range(0, 2) == 0) ? 5'($urandom) : 5'd0;
				offs = pick_offset();
				push_instr(6'(ACT_SB + $urandom_range(0, 2)), 5'($urandom), base,
					5'($urandom), offs);
				push_instr(6'(ACT_LB + $urandom_range(0, 4)), 5'($urandom), base,
					5'($urandom), offs + $urandom_range(0, 3));
				n += 2;
			end else begin
				if (pick < 8) begin
					r13 = $urandom;
					imm = ($urandom_range(0, 3) == 0) ? pick_special($urandom)
						: {{19{r13[12]}}, r13[12:1], 1'b0};
					push_instr(6'($urandom_range(ACT_JAL, ACT_BGEU)), 5'($urandom),
						rs1, rs2, imm);
				end else if (pick < 10) begin
					push_instr(6'($urandom_range(ACT_LUI, ACT_AUIPC)), 5'($urandom),
						rs1, rs2, pick_special($urandom));
				end else if (pick < 11) begin
					push_instr(6'($urandom_range(int'(ACT_SRA) + 1, ACT_CODE_MAX)),
						5'($urandom), rs1, rs2, $urandom);
				end else if (pick < 12) begin
					push_instr(ACT_ADDI, 5'($urandom), 5'd0, rs2, pick_special($urandom));
				end else begin
					push_instr(6'($urandom_range(ACT_ADDI, ACT_SRA)), 5'($urandom),
						rs1, rs2, ($urandom_range(0, 2) == 0) ? pick_special($urandom)
						: $urandom);
				end
				n++;
			end
		end
	endtask

	// Waits until every queued instruction has gone in and every predicted
	// result has come out, then lets the two-stage pipeline settle.
	task automatic wait_drained();
		@(negedge clk);
		while (instr_queue.size() != 0 || s_tvalid || predicted_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reset_pc(logic [31:0] value);
		@(posedge clk);
		reset_pc_we <= 1'b1;
		reset_pc_wdata <= value;
		cfg_reset_pc = value;
		@(posedge clk);
		reset_pc_we <= 1'b0;
	endtask

	// Instruction side. A beat is taken at an edge where tvalid and tready
	// are both high; the model executes it right there, so predictions are
	// made in the same order the unit sees the instructions.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			src_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predicted_results.push_back(execute_instr(cur_instr));
				sent_count++;
				// Every 50 beats the sender may switch into a run with no gaps.
				if (sent_count % 50 == 0)
					src_idle_en = ($urandom_range(0, 2) != 0);
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (instr_queue.size() != 0) begin
					cur_instr = instr_queue.pop_front();
					s_tdata <= {3'b0, cur_instr.imm, cur_instr.rs2, cur_instr.rs1,
						cur_instr.rd, cur_instr.act};
					s_tvalid <= 1'b1;
					src_gap = src_idle_en ? $urandom_range(0, 7) : 0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result side. Each accepted beat is compared field by field with the
	// oldest prediction, then the receiver draws its stall before the next.
	always @(posedge clk or negedge arst_n) begin : result_sink
		result_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_stall = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.next_pc = m_tdata[31:0];
				got.reg_written = m_tdata[32];
				got.written_index = m_tdata[37:33];
				got.written_value = m_tdata[69:38];
				got.branch_taken = m_tdata[70];
				got.mem_kind = mem_kind_t'(m_tdata[72:71]);
				got.mem_address = m_tdata[104:73];
				if (predicted_results.size() == 0) begin
					$error("result beat with no instruction outstanding");
					mismatches++;
				end else begin
					want = predicted_results.pop_front();
					if (got.next_pc !== want.next_pc) begin
						$error("next_pc: expected %h, got %h", want.next_pc, got.next_pc);
						mismatches++;
					end
					if (got.reg_written !== want.reg_written) begin
						$error("reg_written: expected %0d, got %0d",
							want.reg_written, got.reg_written);
						mismatches++;
					end
					if (got.written_index !== want.written_index) begin
						$error("written_index: expected %0d, got %0d",
							want.written_index, got.written_index);
						mismatches++;
					end
					if (got.written_value !== want.written_value) begin
						$error("written_value: expected %h, got %h",
							want.written_value, got.written_value);
						mismatches++;
					end
					if (got.branch_taken !== want.branch_taken) begin
						$error("branch_taken: expected %0d, got %0d",
							want.branch_taken, got.branch_taken);
						mismatches++;
					end
					if (got.mem_kind !== want.mem_kind) begin
						$error("mem_kind: expected %0d, got %0d", want.mem_kind, got.mem_kind);
						mismatches++;
					end
					if (got.mem_address !== want.mem_address) begin
						$error("mem_address: expected %h, got %h",
							want.mem_address, got.mem_address);
						mismatches++;
					end
				end
				taken_results++;
				if (taken_results % 50 == 0)
					sink_idle_en = ($urandom_range(0, 2) != 0);
				// A pending hold request turns this stall into the long hold-off.
				if (long_hold_req) begin
					sink_stall = HOLD_CYCLES;
					long_hold_req = 1'b0;
				end else begin
					sink_stall = sink_idle_en ? $urandom_range(0, 7) : 0;
				end
			end else if (sink_stall > 0) begin
				sink_stall--;
			end
			m_tready <= (sink_stall == 0);
		end
	end

	// Ends the run if neither side moves a beat for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		// The model starts from the reset state: registers and memory zero,
		// reset_pc at its reset value and the PC loaded from it. Later
		// reset_pc writes would only show at another reset, which never comes,
		// so they must leave the PC alone.
		cfg_reset_pc = '0;
		foreach (arch_regs[i])
			arch_regs[i] = '0;
		foreach (data_bytes[i])
			data_bytes[i] = '0;
		arch_pc = cfg_reset_pc;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The unit is still sweeping its memory clear here; reset_pc writes
		// are accepted during the sweep.
		write_reset_pc($urandom);
		queue_directed();

		for (int phase = 0; phase < 5; phase++) begin
			wait_drained();
			write_reset_pc((phase == 4) ? $urandom : pick_special(phase));
			// In the middle phase the receiver stops for a long stretch while
			// the sender keeps offering, so the pipeline fills and s_tready drops.
			if (phase == 2)
				long_hold_req = 1'b1;
			queue_random(182);
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
